// File: sv/tee_pkg.sv
package tee_pkg;

   localparam int MAX_CAPACITY = 4096;
   localparam int CAP_W        = 13;
   localparam int BURST_LEN    = 7;
   localparam int BURST_CNT_W  = 3;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);
   localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(MAX_CAPACITY);

   localparam logic [0:0] ADDR_OUTPUT_CAPACITY = 1'b0;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TILDE  = 8'h7E;

   typedef struct packed {
      logic [BURST_LEN-1:0][7:0] chars;
      logic [BURST_LEN-1:0]      last;
      logic [BURST_CNT_W-1:0]    count;
   } burst_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = 8'h30 + {4'b0, nib};
      end else begin
         ch = 8'h57 + {4'b0, nib};
      end
      return ch;
   endfunction

endpackage

// File: sv/tee_req_if.sv
interface tee_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_string;

   modport source (output valid, in_byte, end_of_string, input ready);
   modport sink   (input valid, in_byte, end_of_string, output ready);
endinterface

// File: sv/tee_rsp_if.sv
interface tee_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       out_last;

   modport source (output valid, out_char, out_last, input ready);
   modport sink   (input valid, out_char, out_last, output ready);
endinterface

// File: sv/text_escape_encoder_unit.sv
// Timing: the first result of an item is valid in the cycle after the item is accepted.
// Throughput: an item producing k results (0..7) holds the result port until all k are taken;
//   the next item is taken in the cycle the previous item's final result is taken,
//   so pass-through bytes stream at one item per cycle while rsp.ready stays high.
// Reset: synchronous, active high; clears count, stop flag and pending results,
//   capacity register returns to 1024.
module text_escape_encoder_unit
   import tee_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tee_req_if.sink     req,
   tee_rsp_if.source   rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [0:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic [CAP_W-1:0] eff_capacity;
   logic             accept;
   logic             can_load;
   burst_type        burst;

   assign pready = 1'b1;
   assign prdata = {{(32-CAP_W){1'b0}}, capacity_ff};

   always_comb begin
      capacity_in = capacity_ff;
      if (psel && penable && pwrite && paddr == ADDR_OUTPUT_CAPACITY) begin
         capacity_in = pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   assign eff_capacity = (capacity_ff > CAP_MAX) ? CAP_MAX : capacity_ff;

   assign req.ready = can_load;
   assign accept    = req.valid && req.ready;

   tee_encode u_encode (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .in_byte       (req.in_byte),
      .end_of_string (req.end_of_string),
      .capacity      (eff_capacity),
      .burst         (burst)
   );

   tee_burst u_burst (
      .clock    (clock),
      .reset    (reset),
      .load     (accept && burst.count != '0),
      .burst    (burst),
      .can_load (can_load),
      .rsp      (rsp)
   );

   a_last_is_nul: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.out_last |-> rsp.out_char == CH_NUL)
      else $error("terminator item carries a nonzero character");

   a_eos_gives_result: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && req.end_of_string |=> rsp.valid)
      else $error("end of string accepted without a pending terminator");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("input stalled while no result is pending");

endmodule

// File: sv/tee_encode.sv
module tee_encode
   import tee_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       in_byte,
   input  logic             end_of_string,
   input  logic [CAP_W-1:0] capacity,
   output burst_type        burst
);

   logic [CAP_W-1:0] written_count_ff, written_count_in;
   logic             stopped_ff, stopped_in;

   logic [5:0][7:0]  buf_chars;
   logic [2:0]       n_chars;
   logic             expanded;
   logic             fit;
   logic [2:0]       emit_n;
   logic [CAP_W:0]   need_one;
   logic [CAP_W:0]   need_all;

   always_comb begin
      buf_chars = '0;
      expanded  = 1'b1;
      n_chars   = 3'd4;
      if (in_byte < CH_SPACE || in_byte > CH_TILDE ||
          in_byte == CH_LBRACK || in_byte == CH_RBRACK) begin
         buf_chars[0] = CH_BSLASH;
         buf_chars[1] = 8'h78;
         buf_chars[2] = hex_char(in_byte[7:4]);
         buf_chars[3] = hex_char(in_byte[3:0]);
      end else if (in_byte == CH_AMP) begin
         buf_chars = {8'h00, CH_SEMI, 8'h70, 8'h6D, 8'h61, CH_AMP};
         n_chars   = 3'd5;
      end else if (in_byte == CH_QUOTE) begin
         buf_chars = {CH_SEMI, 8'h74, 8'h6F, 8'h75, 8'h71, CH_AMP};
         n_chars   = 3'd6;
      end else if (in_byte == CH_LT) begin
         buf_chars = {8'h00, 8'h00, CH_SEMI, 8'h74, 8'h6C, CH_AMP};
      end else if (in_byte == CH_GT) begin
         buf_chars = {8'h00, 8'h00, CH_SEMI, 8'h74, 8'h67, CH_AMP};
      end else begin
         buf_chars[0] = in_byte;
         n_chars      = 3'd1;
         expanded     = 1'b0;
      end
   end

   assign need_one = {1'b0, written_count_ff} + (CAP_W+1)'(1);
   assign need_all = {1'b0, written_count_ff} + (CAP_W+1)'(n_chars)
                     + (CAP_W+1)'(expanded);
   assign fit      = !stopped_ff && (need_one < {1'b0, capacity})
                     && (need_all < {1'b0, capacity});
   assign emit_n   = fit ? n_chars : 3'd0;

   always_comb begin
      burst       = '0;
      burst.count = emit_n + BURST_CNT_W'(end_of_string);
      for (int i = 0; i < BURST_LEN; i++) begin
         if (i < 6 && BURST_CNT_W'(i) < emit_n) begin
            burst.chars[i] = buf_chars[i];
         end else if (BURST_CNT_W'(i) == emit_n && end_of_string) begin
            burst.chars[i] = CH_NUL;
            burst.last[i]  = 1'b1;
         end
      end
   end

   always_comb begin
      written_count_in = written_count_ff;
      stopped_in       = stopped_ff;
      if (accept) begin
         if (end_of_string) begin
            written_count_in = '0;
            stopped_in       = 1'b0;
         end else if (fit) begin
            written_count_in = written_count_ff + CAP_W'(n_chars);
         end else begin
            stopped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_count_ff <= '0;
         stopped_ff       <= 1'b0;
      end else begin
         written_count_ff <= written_count_in;
         stopped_ff       <= stopped_in;
      end
   end

endmodule

// File: sv/tee_burst.sv
module tee_burst
   import tee_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  burst_type burst,
   output logic      can_load,
   tee_rsp_if.source rsp
);

   logic [BURST_LEN-1:0][7:0] chars_ff, chars_in;
   logic [BURST_LEN-1:0]      last_ff, last_in;
   logic [BURST_CNT_W-1:0]    rem_ff, rem_in;
   logic                      take;

   assign take     = (rem_ff != '0) && rsp.ready;
   assign can_load = (rem_ff == '0) || (rem_ff == BURST_CNT_W'(1) && rsp.ready);

   assign rsp.valid    = (rem_ff != '0);
   assign rsp.out_char = chars_ff[0];
   assign rsp.out_last = last_ff[0];

   always_comb begin
      chars_in = chars_ff;
      last_in  = last_ff;
      rem_in   = rem_ff;
      if (load) begin
         chars_in = burst.chars;
         last_in  = burst.last;
         rem_in   = burst.count;
      end else if (take) begin
         chars_in = {8'h00, chars_ff[BURST_LEN-1:1]};
         last_in  = {1'b0, last_ff[BURST_LEN-1:1]};
         rem_in   = rem_ff - BURST_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
      last_ff  <= last_in;
   end

endmodule
